// ===== hdl/pd_pkg.sv =====
// Shared types, character codes and helper functions for the percent decoder.
package pd_pkg;

	localparam logic [7:0] CH_PERCENT = 8'h25;
	localparam logic [7:0] CH_PLUS    = 8'h2B;
	localparam logic [7:0] CH_MINUS   = 8'h2D;
	localparam logic [7:0] CH_SPACE   = 8'h20;
	localparam logic [7:0] CH_TAB     = 8'h09;
	localparam logic [7:0] CH_CR      = 8'h0D;
	localparam logic [7:0] CH_DIG0    = 8'h30;
	localparam logic [7:0] CH_DIG9    = 8'h39;
	localparam logic [7:0] CH_UPA     = 8'h41;
	localparam logic [7:0] CH_UPF     = 8'h46;
	localparam logic [7:0] CH_LOA     = 8'h61;
	localparam logic [7:0] CH_LOF     = 8'h66;

	localparam int unsigned MaxResults = 3;
	localparam int unsigned CntW       = $clog2(MaxResults + 1);

	typedef enum logic [1:0] {
		PH_IDLE,
		PH_PCT,
		PH_HELD
	} phase_t;

	typedef struct packed {
		logic       ok;
		logic [3:0] val;
	} hex_t;

	// Up to three decoded bytes for one input beat, entry 0 goes out first.
	typedef struct packed {
		logic [MaxResults-1:0][7:0] bytes;
		logic [CntW-1:0]            cnt;
		logic                       last;
	} dec_res_t;

	typedef struct packed {
		logic            load_ok;
		logic [CntW-1:0] cnt;
	} rb_stat_t;

	function automatic hex_t hex_val(input logic [7:0] c);
		hex_t h;
		logic [7:0] d;
		h = '0;
		d = '0;
		if (c >= CH_DIG0 && c <= CH_DIG9) begin
			d = c - CH_DIG0;
			h.ok = 1'b1;
		end else if (c >= CH_UPA && c <= CH_UPF) begin
			d = c - CH_UPA + 8'd10;
			h.ok = 1'b1;
		end else if (c >= CH_LOA && c <= CH_LOF) begin
			d = c - CH_LOA + 8'd10;
			h.ok = 1'b1;
		end
		h.val = d[3:0];
		return h;
	endfunction

	function automatic logic is_white(input logic [7:0] c);
		return (c == CH_SPACE) || (c >= CH_TAB && c <= CH_CR);
	endfunction

	// A plain byte: a plus sign becomes a space, everything else passes.
	function automatic logic [7:0] map_plain(input logic [7:0] c);
		return (c == CH_PLUS) ? CH_SPACE : c;
	endfunction

endpackage

// ===== hdl/pd_if.sv =====
// Valid/ready channel interfaces for the encoded input and the decoded output.
interface pd_in_if;
	logic       valid;
	logic       ready;
	logic [7:0] in_byte;
	logic       in_final;

	modport source (output valid, in_byte, in_final, input ready);
	modport sink (input valid, in_byte, in_final, output ready);
endinterface

interface pd_out_if;
	logic       valid;
	logic       ready;
	logic [7:0] out_byte;
	logic       run_end;
	logic       string_end;

	modport source (output valid, out_byte, run_end, string_end, input ready);
	modport sink (input valid, out_byte, run_end, string_end, output ready);
endinterface

// ===== hdl/pd_decode.sv =====
// Decode logic and hold state: turns one registered input byte into up to three output bytes.
module pd_decode
	import pd_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  logic       advance,
	input  logic [7:0] byte_s1,
	input  logic       final_s1,
	output dec_res_t   res
);

	phase_t     hold_phase_q, phase_d;
	logic [7:0] held_byte_q, held_d;
	hex_t       ha, hb;
	logic       pair_ok;
	logic [7:0] pair_val;

	assign ha = hex_val(held_byte_q);
	assign hb = hex_val(byte_s1);

	always_comb begin
		pair_ok  = 1'b0;
		pair_val = '0;
		if (hb.ok) begin
			if (ha.ok) begin
				pair_ok  = 1'b1;
				pair_val = {ha.val, hb.val};
			end else if (is_white(held_byte_q) || held_byte_q == CH_PLUS) begin
				pair_ok  = 1'b1;
				pair_val = {4'd0, hb.val};
			end else if (held_byte_q == CH_MINUS) begin
				pair_ok  = 1'b1;
				pair_val = 8'd0 - {4'd0, hb.val};
			end
		end
	end

	always_comb begin
		res      = '0;
		res.last = final_s1;
		phase_d  = PH_IDLE;
		held_d   = held_byte_q;
		case (hold_phase_q)
			PH_PCT: begin
				if (final_s1) begin
					res.bytes[0] = CH_PERCENT;
					res.bytes[1] = map_plain(byte_s1);
					res.cnt      = CntW'(2);
				end else begin
					phase_d = PH_HELD;
					held_d  = byte_s1;
				end
			end
			PH_HELD: begin
				if (pair_ok) begin
					res.bytes[0] = pair_val;
					res.cnt      = CntW'(1);
				end else if (held_byte_q == CH_PERCENT) begin
					// The held percent starts a new pair attempt of its own.
					res.bytes[0] = CH_PERCENT;
					if (final_s1) begin
						res.bytes[1] = CH_PERCENT;
						res.bytes[2] = map_plain(byte_s1);
						res.cnt      = CntW'(3);
					end else begin
						res.cnt = CntW'(1);
						phase_d = PH_HELD;
						held_d  = byte_s1;
					end
				end else begin
					res.bytes[0] = CH_PERCENT;
					res.bytes[1] = map_plain(held_byte_q);
					if (byte_s1 == CH_PERCENT && !final_s1) begin
						res.cnt = CntW'(2);
						phase_d = PH_PCT;
					end else begin
						res.bytes[2] = map_plain(byte_s1);
						res.cnt      = CntW'(3);
					end
				end
			end
			default: begin
				if (byte_s1 == CH_PERCENT && !final_s1) begin
					phase_d = PH_PCT;
				end else begin
					res.bytes[0] = map_plain(byte_s1);
					res.cnt      = CntW'(1);
				end
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hold_phase_q <= PH_IDLE;
			held_byte_q  <= '0;
		end else if (advance) begin
			hold_phase_q <= phase_d;
			held_byte_q  <= held_d;
		end
	end

endmodule

// ===== hdl/pd_result_buf.sv =====
// Result register that holds the decoded bytes of one input beat and drains them one per beat.
module pd_result_buf
	import pd_pkg::*;
(
	input  logic     clk,
	input  logic     arst_n,
	input  logic     load,
	input  dec_res_t res,
	output rb_stat_t stat,
	pd_out_if.source out_ch
);

	logic [MaxResults-1:0][7:0] bytes_q;
	logic [CntW-1:0]            cnt_q;
	logic                       last_q;
	logic                       one_left;

	assign one_left       = (cnt_q == CntW'(1));
	assign out_ch.valid      = (cnt_q != '0);
	assign out_ch.out_byte   = bytes_q[0];
	assign out_ch.run_end    = one_left;
	assign out_ch.string_end = one_left && last_q;

	assign stat.load_ok = (cnt_q == '0) || (one_left && out_ch.ready);
	assign stat.cnt     = cnt_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
		end else if (load) begin
			cnt_q <= res.cnt;
		end else if (out_ch.valid && out_ch.ready) begin
			cnt_q <= cnt_q - CntW'(1);
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			bytes_q <= res.bytes;
			last_q  <= res.last;
		end else if (out_ch.valid && out_ch.ready) begin
			for (int i = 0; i < MaxResults - 1; i++) begin
				bytes_q[i] <= bytes_q[i+1];
			end
		end
	end

endmodule

// ===== hdl/percent_decoder.sv =====
// Percent decoder top level: input register, decode logic and draining result register.
// A byte accepted into the input register is decoded and loaded into the result register once
// that register can take it; the result register then offers its first output beat, if any.
// Throughput: one input beat per cycle while the output is ready and every beat yields at most
// one output byte; a beat with two or three bytes holds the input until its last byte is taken.
// Reset (arst_n low, asynchronous) empties the input and result registers and clears the hold.
module percent_decoder
	import pd_pkg::*;
(
	input  logic     clk,
	input  logic     arst_n,
	pd_in_if.sink    in_ch,
	pd_out_if.source out_ch
);

	logic       valid_s1;
	logic [7:0] byte_s1;
	logic       final_s1;
	logic       advance;
	dec_res_t   res;
	rb_stat_t   stat;

	assign advance     = valid_s1 && stat.load_ok;
	assign in_ch.ready = !valid_s1 || stat.load_ok;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ch.valid && in_ch.ready) begin
			valid_s1 <= 1'b1;
		end else if (advance) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ch.valid && in_ch.ready) begin
			byte_s1  <= in_ch.in_byte;
			final_s1 <= in_ch.in_final;
		end
	end

	pd_decode u_decode (
		.clk      (clk),
		.arst_n   (arst_n),
		.advance  (advance),
		.byte_s1  (byte_s1),
		.final_s1 (final_s1),
		.res      (res)
	);

	pd_result_buf u_result (
		.clk    (clk),
		.arst_n (arst_n),
		.load   (advance),
		.res    (res),
		.stat   (stat),
		.out_ch (out_ch)
	);

	// A registered byte that the result register cannot take must stay put.
	a_s1_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s1 && !stat.load_ok) |=> (valid_s1 && $stable(byte_s1) && $stable(final_s1)))
		else $error("input register lost or changed a stalled byte");

	// The final byte of a string always produces at least one output beat.
	a_final_out: assert property (@(posedge clk) disable iff (!arst_n)
		(advance && final_s1) |=> (stat.cnt != '0))
		else $error("final byte produced no output");

	// The result register is never reloaded while more than one byte is still waiting.
	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		advance |-> (stat.cnt == '0 || (stat.cnt == CntW'(1) && out_ch.ready)))
		else $error("result register overwritten with bytes pending");

	// The string end flag only ever marks the last byte of a beat.
	a_end_flags: assert property (@(posedge clk) disable iff (!arst_n)
		(out_ch.valid && out_ch.string_end) |-> out_ch.run_end)
		else $error("string end without run end");

endmodule
